[design/sei_pkg.sv]
package sei_pkg;

    localparam int NUM_STAGES_DEF = 4;
    localparam int MAX_JOINTS_DEF = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_W     = 9;
    localparam int STAGE_W    = 2;
    localparam int TGT_W      = 3;
    localparam int CNT_W      = 32;
    localparam int WIN_W      = 32;
    localparam int NEED_W     = 16;
    localparam int JOINT_W    = 4;
    localparam int SCALE_W    = 8;

    localparam logic [NEED_W-1:0] MIN_CYCLES_RST = NEED_W'(200);
    localparam logic [CNT_W-1:0]  CNT_MAX        = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MONOTONIC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CYCLES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_0    = 3'd3;

    // block_mask bit positions
    localparam int MB_UNKNOWN = 0;
    localparam int MB_JUMP    = 1;
    localparam int MB_SCALE   = 2;
    localparam int MB_POSE    = 3;
    localparam int MB_SIGN    = 4;
    localparam int MB_ORDER   = 5;
    localparam int MB_NOACT   = 6;
    localparam int MB_MOTOR   = 7;
    localparam int MB_SHORT   = 8;

    typedef enum logic [1:0] {
        FUNC_REQUEST = 2'd0,
        FUNC_CYCLE   = 2'd1,
        FUNC_QUERY   = 2'd2
    } func_t;

    typedef struct packed {
        logic [SCALE_W-1:0] kd_gain;
        logic [SCALE_W-1:0] kp_gain;
        logic [SCALE_W-1:0] act_scale;
        logic [JOINT_W-1:0] joints;
        logic               motor;
        logic               need_order;
        logic               need_sign;
        logic               need_pose;
        logic [NEED_W-1:0]  active_cycles;
        logic [NEED_W-1:0]  min_cycles;
    } stage_word_t;

    typedef struct packed {
        logic              monotonic_only;
        logic              hold_before_scale_up;
        logic [NEED_W-1:0] min_cycles_active;
    } cfg_ctrl_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [TGT_W-1:0] tgt_stage;
        logic             hold_ack;
        logic             pose_check_ok;
        logic             sign_check_ok;
        logic             order_check_ok;
        logic             fault;
        logic [WIN_W-1:0] window_start;
        logic [WIN_W-1:0] window_end;
        logic [WIN_W-1:0] window_stride;
    } item_t;

    typedef struct packed {
        logic               ok;
        logic [MASK_W-1:0]  block_mask;
        logic [STAGE_W-1:0] stage_now;
        logic               counter_cleared;
        logic [CNT_W-1:0]   clean_cycles;
        logic [NEED_W-1:0]  cycles_needed;
        logic               need_met;
        logic               bad_window;
    } result_t;

    function automatic logic [JOINT_W-1:0] joints_of(stage_word_t w,
                                                     logic [JOINT_W-1:0] max_j);
        return (w.joints > max_j) ? max_j : w.joints;
    endfunction

    function automatic logic [NEED_W-1:0] max16(logic [NEED_W-1:0] a,
                                                logic [NEED_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [NEED_W-1:0] need_stage(stage_word_t w,
                                                     logic [NEED_W-1:0] floor_c);
        if (w.min_cycles == '0 && w.active_cycles == '0) begin
            return '0;
        end
        return max16(floor_c, max16(w.min_cycles, w.active_cycles));
    endfunction

    function automatic logic [NEED_W-1:0] need_active(stage_word_t w,
                                                      logic [NEED_W-1:0] floor_c);
        if (w.active_cycles == '0) begin
            return '0;
        end
        return max16(floor_c, w.active_cycles);
    endfunction

    function automatic logic limits_differ(stage_word_t a, stage_word_t b,
                                           logic [JOINT_W-1:0] max_j);
        return (a.motor != b.motor) || (joints_of(a, max_j) != joints_of(b, max_j)) ||
               ({a.kd_gain, a.kp_gain, a.act_scale} !=
                {b.kd_gain, b.kp_gain, b.act_scale});
    endfunction

    function automatic logic more_permissive(stage_word_t cur, stage_word_t tgt,
                                             logic [JOINT_W-1:0] max_j);
        return (!cur.motor && tgt.motor) ||
               (joints_of(tgt, max_j) > joints_of(cur, max_j)) ||
               (tgt.act_scale > cur.act_scale) ||
               (tgt.kp_gain > cur.kp_gain) ||
               (tgt.kd_gain > cur.kd_gain);
    endfunction

    function automatic logic [MASK_W-1:0] check_mask(stage_word_t w, logic pose_ok,
                                                     logic sign_ok, logic order_ok);
        logic [MASK_W-1:0] m;
        m = '0;
        m[MB_POSE]  = w.need_pose && !pose_ok;
        m[MB_SIGN]  = w.need_sign && !sign_ok;
        m[MB_ORDER] = w.need_order && !order_ok;
        return m;
    endfunction

endpackage

[design/stage_escalation_interlock.sv]
// Stage escalation interlock. Each transaction on the s_ channel yields exactly one
// transaction on the m_ channel, in order. A transaction is registered on entry,
// evaluated combinationally against the stage state and registered again on exit, and
// its result is presented on m_ from that output register; one transaction per cycle
// is sustained while m_ready stays high, and the throughput is set only by the output
// register handshake. Configuration writes take effect on the next cycle and are
// meant for when no transaction is in flight.
module stage_escalation_interlock #(
    parameter int NUM_STAGES = sei_pkg::NUM_STAGES_DEF,
    parameter int MAX_JOINTS = sei_pkg::MAX_JOINTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sei_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sei_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_func,
    input  logic [sei_pkg::TGT_W-1:0]      s_tgt_stage,
    input  logic                           s_hold_ack,
    input  logic                           s_pose_check_ok,
    input  logic                           s_sign_check_ok,
    input  logic                           s_order_check_ok,
    input  logic                           s_fault,
    input  logic [sei_pkg::WIN_W-1:0]      s_window_start,
    input  logic [sei_pkg::WIN_W-1:0]      s_window_end,
    input  logic [sei_pkg::WIN_W-1:0]      s_window_stride,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic [sei_pkg::MASK_W-1:0]     m_block_mask,
    output logic [sei_pkg::STAGE_W-1:0]    m_stage_now,
    output logic                           m_counter_cleared,
    output logic [sei_pkg::CNT_W-1:0]      m_clean_cycles,
    output logic [sei_pkg::NEED_W-1:0]     m_cycles_needed,
    output logic                           m_need_met,
    output logic                           m_bad_window
);
    import sei_pkg::*;

    cfg_ctrl_t   ctrl;
    stage_word_t stage_words [NUM_STAGES];
    item_t       item_reg;
    result_t     core_res, res_reg;
    logic        in_valid_reg, in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic        advance, fire;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func           <= s_func;
            item_reg.tgt_stage      <= s_tgt_stage;
            item_reg.hold_ack       <= s_hold_ack;
            item_reg.pose_check_ok  <= s_pose_check_ok;
            item_reg.sign_check_ok  <= s_sign_check_ok;
            item_reg.order_check_ok <= s_order_check_ok;
            item_reg.fault          <= s_fault;
            item_reg.window_start   <= s_window_start;
            item_reg.window_end     <= s_window_end;
            item_reg.window_stride  <= s_window_stride;
        end
        if (fire) begin
            res_reg <= core_res;
        end
    end

    sei_cfg #(
        .NUM_STAGES (NUM_STAGES)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .ctrl        (ctrl),
        .stage_words (stage_words)
    );

    sei_core #(
        .NUM_STAGES (NUM_STAGES),
        .MAX_JOINTS (MAX_JOINTS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .stage_words (stage_words),
        .item        (item_reg),
        .fire        (fire),
        .result      (core_res)
    );

    assign m_valid           = out_valid_reg;
    assign m_ok              = res_reg.ok;
    assign m_block_mask      = res_reg.block_mask;
    assign m_stage_now       = res_reg.stage_now;
    assign m_counter_cleared = res_reg.counter_cleared;
    assign m_clean_cycles    = res_reg.clean_cycles;
    assign m_cycles_needed   = res_reg.cycles_needed;
    assign m_need_met        = res_reg.need_met;
    assign m_bad_window      = res_reg.bad_window;

endmodule

[design/sei_cfg.sv]
module sei_cfg #(
    parameter int NUM_STAGES = sei_pkg::NUM_STAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [sei_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sei_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output sei_pkg::cfg_ctrl_t             ctrl,
    output sei_pkg::stage_word_t           stage_words [NUM_STAGES]
);
    import sei_pkg::*;

    cfg_ctrl_t   ctrl_reg;
    stage_word_t words_reg [NUM_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.monotonic_only       <= 1'b1;
            ctrl_reg.hold_before_scale_up <= 1'b1;
            ctrl_reg.min_cycles_active    <= MIN_CYCLES_RST;
            for (int k = 0; k < NUM_STAGES; k++) begin
                words_reg[k] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MONOTONIC:  ctrl_reg.monotonic_only <= cfg_wr_data[0];
                CFG_HOLD:       ctrl_reg.hold_before_scale_up <= cfg_wr_data[0];
                CFG_MIN_CYCLES: ctrl_reg.min_cycles_active <= cfg_wr_data[NEED_W-1:0];
                default: begin
                    for (int k = 0; k < NUM_STAGES; k++) begin
                        if (cfg_index == CFG_IDX_W'(CFG_STAGE_0 + k)) begin
                            words_reg[k] <= stage_word_t'(cfg_wr_data);
                        end
                    end
                end
            endcase
        end
    end

    assign ctrl        = ctrl_reg;
    assign stage_words = words_reg;

endmodule

[design/sei_core.sv]
module sei_core #(
    parameter int NUM_STAGES = sei_pkg::NUM_STAGES_DEF,
    parameter int MAX_JOINTS = sei_pkg::MAX_JOINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sei_pkg::cfg_ctrl_t   ctrl,
    input  sei_pkg::stage_word_t stage_words [NUM_STAGES],
    input  sei_pkg::item_t       item,
    input  logic                 fire,
    output sei_pkg::result_t     result
);
    import sei_pkg::*;

    localparam int IDX_W = $clog2(NUM_STAGES);
    localparam logic [JOINT_W-1:0] MAX_J   = JOINT_W'(MAX_JOINTS);
    localparam logic [TGT_W-1:0]   NUM_TGT = TGT_W'(NUM_STAGES);

    logic [IDX_W-1:0] stage_idx_reg, stage_idx_next;
    logic [CNT_W-1:0] clean_reg, clean_next;
    logic             seen_reg, seen_next;
    logic [WIN_W-1:0] last_start_reg, last_start_next;
    logic [WIN_W-1:0] last_end_reg, last_end_next;
    logic [WIN_W-1:0] last_stride_reg, last_stride_next;

    stage_word_t       cur_word, tgt_word, new_word;
    logic              known, jump_up, changed, ok, cleared, bad;
    logic [IDX_W-1:0]  tgt_idx;
    logic [MASK_W-1:0] mask;
    logic [NEED_W-1:0] need;
    func_t             func;

    always_comb begin
        stage_idx_next   = stage_idx_reg;
        clean_next       = clean_reg;
        seen_next        = seen_reg;
        last_start_next  = last_start_reg;
        last_end_next    = last_end_reg;
        last_stride_next = last_stride_reg;
        ok      = 1'b0;
        mask    = '0;
        cleared = 1'b0;
        bad     = 1'b0;
        func    = func_t'(item.func);

        known    = item.tgt_stage < NUM_TGT;
        tgt_idx  = item.tgt_stage[IDX_W-1:0];
        cur_word = stage_words[stage_idx_reg];
        tgt_word = known ? stage_words[tgt_idx] : cur_word;
        jump_up  = (TGT_W+1)'(item.tgt_stage) >
                   ((TGT_W+1)'(stage_idx_reg) + (TGT_W+1)'(1));
        changed  = seen_reg && (last_start_reg != item.window_start ||
                                last_end_reg != item.window_end ||
                                last_stride_reg != item.window_stride);

        case (func)
            FUNC_REQUEST: begin
                if (!known) begin
                    mask[MB_UNKNOWN] = 1'b1;
                end else begin
                    mask[MB_JUMP]  = ctrl.monotonic_only && jump_up;
                    mask[MB_SCALE] = more_permissive(cur_word, tgt_word, MAX_J) &&
                                     ctrl.hold_before_scale_up && !item.hold_ack;
                    mask = mask | check_mask(tgt_word, item.pose_check_ok,
                                             item.sign_check_ok, item.order_check_ok);
                    if (mask == '0) begin
                        ok             = 1'b1;
                        stage_idx_next = tgt_idx;
                        if (limits_differ(cur_word, tgt_word, MAX_J)) begin
                            clean_next = '0;
                            cleared    = 1'b1;
                        end
                    end
                end
            end
            FUNC_CYCLE: begin
                if (item.window_end < item.window_start || item.window_stride == '0) begin
                    bad = 1'b1;
                end else begin
                    last_start_next  = item.window_start;
                    last_end_next    = item.window_end;
                    last_stride_next = item.window_stride;
                    seen_next        = 1'b1;
                    if (changed || item.fault) begin
                        clean_next = '0;
                        cleared    = 1'b1;
                    end else if (clean_reg != CNT_MAX) begin
                        clean_next = clean_reg + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase

        new_word = stage_words[stage_idx_next];
        if (func == FUNC_QUERY) begin
            need = need_active(new_word, ctrl.min_cycles_active);
            mask[MB_NOACT] = (need == '0);
            mask[MB_MOTOR] = !new_word.motor;
            mask = mask | check_mask(new_word, item.pose_check_ok,
                                     item.sign_check_ok, item.order_check_ok);
            mask[MB_SHORT] = clean_next < CNT_W'(need);
            ok = (mask == '0);
        end else begin
            need = need_stage(new_word, ctrl.min_cycles_active);
        end

        result.ok              = ok;
        result.block_mask      = mask;
        result.stage_now       = STAGE_W'(stage_idx_next);
        result.counter_cleared = cleared;
        result.clean_cycles    = clean_next;
        result.cycles_needed   = need;
        result.need_met        = (need == '0) || (clean_next >= CNT_W'(need));
        result.bad_window      = bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_idx_reg   <= '0;
            clean_reg       <= '0;
            seen_reg        <= 1'b0;
            last_start_reg  <= '0;
            last_end_reg    <= '0;
            last_stride_reg <= '0;
        end else if (fire) begin
            stage_idx_reg   <= stage_idx_next;
            clean_reg       <= clean_next;
            seen_reg        <= seen_next;
            last_start_reg  <= last_start_next;
            last_end_reg    <= last_end_next;
            last_stride_reg <= last_stride_next;
        end
    end

endmodule

[design/sei_checker.sv]
module sei_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_ok,
    input logic [sei_pkg::MASK_W-1:0]     m_block_mask,
    input logic [sei_pkg::STAGE_W-1:0]    m_stage_now,
    input logic                           m_counter_cleared,
    input logic [sei_pkg::CNT_W-1:0]      m_clean_cycles,
    input logic [sei_pkg::NEED_W-1:0]     m_cycles_needed,
    input logic                           m_need_met,
    input logic                           m_bad_window
);
    import sei_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_stage_now) &&
        $stable(m_clean_cycles) && $stable(m_block_mask) && $stable(m_ok))
        else $error("result changed while stalled");

    a_bad_window_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_window |-> !m_ok && m_block_mask == '0 && !m_counter_cleared)
        else $error("bad window transaction reported activity");

    a_unknown_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_mask[MB_UNKNOWN] |->
        m_block_mask == MASK_W'(1) && !m_ok)
        else $error("unknown stage combined with other blocks");

    a_cleared_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_counter_cleared |-> m_clean_cycles == '0)
        else $error("cleared counter is not zero");

    a_need_met: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_need_met == (m_cycles_needed == '0 ||
                                   m_clean_cycles >= CNT_W'(m_cycles_needed)))
        else $error("need_met inconsistent with count");

endmodule

bind stage_escalation_interlock sei_checker u_sei_checker (.*);

[bench/tb_stage_escalation_interlock.sv]
module tb_stage_escalation_interlock;
    timeunit 1ns;
    timeprecision 1ps;

    import sei_pkg::*;

    localparam int N_STAGES    = NUM_STAGES_DEF;
    localparam int JOINT_CAP   = MAX_JOINTS_DEF;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_W      = $bits(item_t);
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    item_t tx_item = '0;

    logic m_ok;
    logic [MASK_W-1:0] m_block_mask;
    logic [STAGE_W-1:0] m_stage_now;
    logic m_counter_cleared;
    logic [CNT_W-1:0] m_clean_cycles;
    logic [NEED_W-1:0] m_cycles_needed;
    logic m_need_met;
    logic m_bad_window;

    // interlock model state
    logic mono_cfg;
    logic hold_cfg;
    logic [NEED_W-1:0] floor_cfg;
    stage_word_t stage_words [4];
    logic [STAGE_W-1:0] stage_idx;
    logic [CNT_W-1:0] clean_cnt;
    logic win_valid;
    logic [WIN_W-1:0] last_ws, last_we, last_wst;

    item_t requests_to_send [$];
    result_t pending_verdicts [$];
    logic in_taken = 1'b0;
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int errors = 0;
    int stall_cycles = 0;

    int n_results = 0, n_granted = 0, n_allowed = 0, n_bad = 0, n_cleared = 0;
    logic [CNT_W-1:0] peak_clean = '0;

    logic [WIN_W-1:0] gen_ws = 32'd0, gen_we = 32'd100, gen_wst = 32'd1;

    int mono_plan  [N_PHASES] = '{1, 0, 1, 1, 0, 0, 1, 0};
    int hold_plan  [N_PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1};
    int floor_plan [N_PHASES] = '{5, 0, 65535, 3, 1, 200, 0, 12};

    stage_escalation_interlock i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (tx_item.func),
        .s_tgt_stage      (tx_item.tgt_stage),
        .s_hold_ack       (tx_item.hold_ack),
        .s_pose_check_ok  (tx_item.pose_check_ok),
        .s_sign_check_ok  (tx_item.sign_check_ok),
        .s_order_check_ok (tx_item.order_check_ok),
        .s_fault          (tx_item.fault),
        .s_window_start   (tx_item.window_start),
        .s_window_end     (tx_item.window_end),
        .s_window_stride  (tx_item.window_stride),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_block_mask     (m_block_mask),
        .m_stage_now      (m_stage_now),
        .m_counter_cleared(m_counter_cleared),
        .m_clean_cycles   (m_clean_cycles),
        .m_cycles_needed  (m_cycles_needed),
        .m_need_met       (m_need_met),
        .m_bad_window     (m_bad_window)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int capped_joints(stage_word_t w);
        return (int'(w.joints) > JOINT_CAP) ? JOINT_CAP : int'(w.joints);
    endfunction

    function automatic logic [NEED_W-1:0] larger(logic [NEED_W-1:0] a, logic [NEED_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [MASK_W-1:0] missing_checks(stage_word_t w, item_t it);
        logic [MASK_W-1:0] m;
        m = '0;
        if (w.need_pose && !it.pose_check_ok) m[MB_POSE] = 1'b1;
        if (w.need_sign && !it.sign_check_ok) m[MB_SIGN] = 1'b1;
        if (w.need_order && !it.order_check_ok) m[MB_ORDER] = 1'b1;
        return m;
    endfunction

    function automatic result_t evaluate_interlock(item_t it);
        result_t r;
        stage_word_t cur, tgt_w;
        logic changed, widens;
        logic [NEED_W-1:0] need;
        r = '0;
        cur = stage_words[stage_idx];
        if (it.func == FUNC_REQUEST) begin
            if (int'(it.tgt_stage) >= N_STAGES) begin
                r.block_mask[MB_UNKNOWN] = 1'b1;
            end else begin
                tgt_w = stage_words[it.tgt_stage[STAGE_W-1:0]];
                widens = (!cur.motor && tgt_w.motor) ||
                         capped_joints(tgt_w) > capped_joints(cur) ||
                         tgt_w.act_scale > cur.act_scale ||
                         tgt_w.kp_gain > cur.kp_gain ||
                         tgt_w.kd_gain > cur.kd_gain;
                if (mono_cfg && int'(it.tgt_stage) > int'(stage_idx) + 1)
                    r.block_mask[MB_JUMP] = 1'b1;
                if (hold_cfg && !it.hold_ack && widens)
                    r.block_mask[MB_SCALE] = 1'b1;
                r.block_mask |= missing_checks(tgt_w, it);
                if (r.block_mask == '0) begin
                    r.ok = 1'b1;
                    stage_idx = it.tgt_stage[STAGE_W-1:0];
                    if (cur.motor != tgt_w.motor ||
                        capped_joints(cur) != capped_joints(tgt_w) ||
                        {cur.kd_gain, cur.kp_gain, cur.act_scale} !=
                        {tgt_w.kd_gain, tgt_w.kp_gain, tgt_w.act_scale}) begin
                        clean_cnt = '0;
                        r.counter_cleared = 1'b1;
                    end
                end
            end
        end else if (it.func == FUNC_CYCLE) begin
            if (it.window_end < it.window_start || it.window_stride == '0) begin
                r.bad_window = 1'b1;
            end else begin
                changed = win_valid && ({last_ws, last_we, last_wst} !=
                          {it.window_start, it.window_end, it.window_stride});
                last_ws = it.window_start;
                last_we = it.window_end;
                last_wst = it.window_stride;
                win_valid = 1'b1;
                if (changed || it.fault) begin
                    clean_cnt = '0;
                    r.counter_cleared = 1'b1;
                end else if (clean_cnt != CNT_MAX) begin
                    clean_cnt = clean_cnt + 1'b1;
                end
            end
        end
        cur = stage_words[stage_idx];
        if (it.func == FUNC_QUERY) begin
            need = (cur.active_cycles == '0) ? '0 : larger(floor_cfg, cur.active_cycles);
            if (need == '0) r.block_mask[MB_NOACT] = 1'b1;
            if (!cur.motor) r.block_mask[MB_MOTOR] = 1'b1;
            r.block_mask |= missing_checks(cur, it);
            if (clean_cnt < CNT_W'(need)) r.block_mask[MB_SHORT] = 1'b1;
            r.ok = (r.block_mask == '0);
        end else if (cur.min_cycles == '0 && cur.active_cycles == '0) begin
            need = '0;
        end else begin
            need = larger(floor_cfg, larger(cur.min_cycles, cur.active_cycles));
        end
        r.stage_now = stage_idx;
        r.clean_cycles = clean_cnt;
        r.cycles_needed = need;
        r.need_met = (need == '0) || (clean_cnt >= CNT_W'(need));
        return r;
    endfunction

    task automatic check_field(string name, logic [CNT_W-1:0] expv, logic [CNT_W-1:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
            errors++;
        end
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (requests_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    tx_item <= requests_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result transaction with nothing expected", $time);
                errors++;
            end else begin
                exp_r = pending_verdicts.pop_front();
                check_field("ok", CNT_W'(exp_r.ok), CNT_W'(m_ok));
                check_field("block_mask", CNT_W'(exp_r.block_mask), CNT_W'(m_block_mask));
                check_field("stage_now", CNT_W'(exp_r.stage_now), CNT_W'(m_stage_now));
                check_field("counter_cleared", CNT_W'(exp_r.counter_cleared),
                            CNT_W'(m_counter_cleared));
                check_field("clean_cycles", exp_r.clean_cycles, m_clean_cycles);
                check_field("cycles_needed", CNT_W'(exp_r.cycles_needed),
                            CNT_W'(m_cycles_needed));
                check_field("need_met", CNT_W'(exp_r.need_met), CNT_W'(m_need_met));
                check_field("bad_window", CNT_W'(exp_r.bad_window), CNT_W'(m_bad_window));
                n_results++;
            end
        end
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            exp_r = evaluate_interlock(tx_item);
            pending_verdicts.insert(pending_verdicts.size(), exp_r);
            if (tx_item.func == FUNC_REQUEST && exp_r.ok) n_granted++;
            if (tx_item.func == FUNC_QUERY && exp_r.ok) n_allowed++;
            if (exp_r.bad_window) n_bad++;
            if (exp_r.counter_cleared) n_cleared++;
            if (exp_r.clean_cycles > peak_clean) peak_clean = exp_r.clean_cycles;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (requests_to_send.size() == 0 && !s_valid && pending_verdicts.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        case (idx)
            CFG_MONOTONIC:  mono_cfg = data[0];
            CFG_HOLD:       hold_cfg = data[0];
            CFG_MIN_CYCLES: floor_cfg = data[NEED_W-1:0];
            default:        stage_words[STAGE_W'(idx - CFG_STAGE_0)] = data;
        endcase
    endtask

    task automatic wait_drained();
        while (requests_to_send.size() != 0 || s_valid || pending_verdicts.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic add_item(logic [1:0] f, int tgt, int hold, int pose, int sign, int order,
                            int flt, logic [WIN_W-1:0] ws, logic [WIN_W-1:0] we,
                            logic [WIN_W-1:0] wst);
        item_t it;
        it.func = f;
        it.tgt_stage = TGT_W'(tgt);
        it.hold_ack = 1'(hold);
        it.pose_check_ok = 1'(pose);
        it.sign_check_ok = 1'(sign);
        it.order_check_ok = 1'(order);
        it.fault = 1'(flt);
        it.window_start = ws;
        it.window_end = we;
        it.window_stride = wst;
        requests_to_send.insert(requests_to_send.size(), it);
    endtask

    function automatic logic [NEED_W-1:0] pick_cycles();
        int r;
        r = $urandom_range(9);
        if (r < 3) return '0;
        if (r < 8) return NEED_W'($urandom_range(1, 12));
        if (r == 8) return '1;
        return NEED_W'($urandom);
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'h10;
            2: return 8'h18;
            3: return 8'hFF;
            default: return SCALE_W'($urandom);
        endcase
    endfunction

    function automatic stage_word_t random_stage(stage_word_t prev);
        stage_word_t w;
        w.min_cycles = pick_cycles();
        w.active_cycles = pick_cycles();
        w.need_pose = ($urandom_range(3) == 0);
        w.need_sign = ($urandom_range(3) == 0);
        w.need_order = ($urandom_range(3) == 0);
        w.motor = 1'($urandom_range(1));
        w.joints = JOINT_W'($urandom_range(15));
        w.act_scale = pick_scale();
        w.kp_gain = pick_scale();
        w.kd_gain = pick_scale();
        // shared limits so some stage changes keep the counter
        if ($urandom_range(9) < 3) begin
            w.motor = prev.motor;
            w.joints = prev.joints;
            w.act_scale = prev.act_scale;
            w.kp_gain = prev.kp_gain;
            w.kd_gain = prev.kd_gain;
        end
        return w;
    endfunction

    task automatic random_item();
        item_t it;
        int r;
        logic [WIN_W-1:0] a, b;
        it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
        it.fault = ($urandom_range(99) < 8);
        r = $urandom_range(99);
        if (r < 30) begin
            it.func = FUNC_REQUEST;
            it.tgt_stage = ($urandom_range(9) < 8) ? TGT_W'($urandom_range(3))
                                                    : TGT_W'($urandom_range(4, 7));
            it.hold_ack = ($urandom_range(9) < 8);
            it.pose_check_ok = ($urandom_range(99) < 85);
            it.sign_check_ok = ($urandom_range(99) < 85);
            it.order_check_ok = ($urandom_range(99) < 85);
        end else if (r < 76) begin
            it.func = FUNC_CYCLE;
            r = $urandom_range(99);
            a = $urandom;
            b = $urandom;
            if (r < 10) begin
                gen_ws = (a < b) ? a : b;
                gen_we = (a < b) ? b : a;
                gen_wst = ($urandom_range(1)) ? WIN_W'($urandom_range(1, 8)) : $urandom;
                if (gen_wst == '0) gen_wst = 32'd1;
            end
            if (r < 80) begin
                it.window_start = gen_ws;
                it.window_end = gen_we;
                it.window_stride = gen_wst;
            end else if (r < 88) begin
                if (a == b) b = ~a;
                it.window_start = (a > b) ? a : b;
                it.window_end = (a > b) ? b : a;
            end else if (r < 94) begin
                it.window_start = gen_ws;
                it.window_end = gen_we;
                it.window_stride = '0;
            end
        end else if (r < 96) begin
            it.func = FUNC_QUERY;
            it.pose_check_ok = ($urandom_range(99) < 85);
            it.sign_check_ok = ($urandom_range(99) < 85);
            it.order_check_ok = ($urandom_range(99) < 85);
        end else begin
            it.func = FUNC_UNUSED;
        end
        requests_to_send.insert(requests_to_send.size(), it);
    endtask

    initial begin
        int ph, k;
        stage_word_t w;
        mono_cfg = 1'b1;
        hold_cfg = 1'b1;
        floor_cfg = MIN_CYCLES_RST;
        for (k = 0; k < 4; k++) stage_words[k] = '0;
        stage_idx = '0;
        clean_cnt = '0;
        win_valid = 1'b0;
        last_ws = '0;
        last_we = '0;
        last_wst = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset-value configuration
        add_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(FUNC_REQUEST, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, 32'd0, 32'd0, 32'd1);
        add_item(FUNC_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++) begin
            sender_idle_pct = (ph % 4 == 1) ? 65 : (ph % 4 == 3) ? 32 : 0;
            sink_stall_pct = (ph % 4 == 2) ? 65 : (ph % 4 == 3) ? 32 : 0;
            write_reg(CFG_MONOTONIC, CFG_DATA_W'(mono_plan[ph]));
            write_reg(CFG_HOLD, CFG_DATA_W'(hold_plan[ph]));
            write_reg(CFG_MIN_CYCLES, CFG_DATA_W'(floor_plan[ph]));
            if (ph == 0) begin
                w = '0;
                w.min_cycles = 16'd2;
                w.joints = 4'd4;
                w.act_scale = 8'h10;
                w.kp_gain = 8'h10;
                w.kd_gain = 8'h10;
                write_reg(CFG_STAGE_0, w);
                w.min_cycles = '0;
                w.need_pose = 1'b1;
                write_reg(CFG_IDX_W'(CFG_STAGE_0 + 1), w);
                w = '0;
                w.min_cycles = 16'd1;
                w.active_cycles = 16'd3;
                w.need_sign = 1'b1;
                w.need_order = 1'b1;
                w.motor = 1'b1;
                w.joints = 4'd15;
                w.act_scale = 8'h20;
                w.kp_gain = 8'h10;
                w.kd_gain = 8'h10;
                write_reg(CFG_IDX_W'(CFG_STAGE_0 + 2), w);
                write_reg(CFG_IDX_W'(CFG_STAGE_0 + 3), '1);
            end else begin
                w = stage_words[3];
                for (k = 0; k < 4; k++) begin
                    w = random_stage(w);
                    write_reg(CFG_STAGE_0 + CFG_IDX_W'(k), w);
                end
            end
            @(negedge aclk);
            cfg_wr_en <= 1'b0;

            if (ph == 0) begin
                add_item(FUNC_QUERY, 0, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 7, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 4, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 2, 0, 0, 0, 0, 0, 0, 0, 0);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, 32'd0, 32'd0, 32'd1);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, 32'd0, 32'd0, 32'd1);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 1, 32'd0, 32'd0, 32'd1);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, '1, 32'd0, 32'd1);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, 32'd5, 32'd9, 32'd0);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, '1, '1, '1);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, '1, '1, '1);
                add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, '1, '1, '1);
                add_item(FUNC_REQUEST, 1, 1, 0, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 1, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 2, 0, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 2, 1, 1, 0, 0, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 2, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_QUERY, 0, 1, 1, 1, 1, 0, 0, 0, 0);
                for (k = 0; k < 5; k++)
                    add_item(FUNC_CYCLE, 0, 0, 0, 0, 0, 0, '1, '1, '1);
                add_item(FUNC_QUERY, 0, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_UNUSED, 0, 1, 1, 1, 1, 1, '1, 0, 0);
                add_item(FUNC_REQUEST, 3, 1, 1, 1, 1, 0, 0, 0, 0);
                add_item(FUNC_REQUEST, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            end
            for (k = 0; k < PHASE_ITEMS; k++) random_item();
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        $display("Checked %0d results over %0d configurations and four flow-control modes.",
                 n_results, N_PHASES);
        $display("Stage changes granted %0d, active grants %0d, rejected windows %0d, %s %0d, %s %0d.",
                 n_granted, n_allowed, n_bad, "counter clears", n_cleared,
                 "peak clean count", peak_clean);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
